/* sv/ggb_pkg.sv */
// shared types and constants of the generalized goertzel bin
package ggb_pkg;

   localparam int DEF_MAX_FRAME = 4096;
   localparam int DEF_ACC_WIDTH = 48;

   localparam int SAMPLE_W = 16;
   localparam int BIN_W    = 48;
   localparam int COEF_W   = 18;
   localparam int CC_W     = 16;
   localparam int FLEN_W   = 13;

   localparam int REC_SHIFT = 16;
   localparam int BIN_SHIFT = 14;

   // power of two, pointers wrap naturally
   localparam int QUEUE_DEPTH = 2;

   localparam int PADDR_W   = 5;
   localparam int CSR_IDX_W = 3;
   localparam int PDATA_W   = 32;

   localparam logic [CSR_IDX_W-1:0] REG_COEF         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_CC2_RE       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_CC2_IM       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CC_RE        = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CC_IM        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_FRAME_LENGTH = 3'd5;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] sample;
      logic                       last;
   } qentry_type;

   typedef struct packed {
      logic       push;
      qentry_type entry;
   } queue_wr_type;

   typedef struct packed {
      logic       valid;
      qentry_type entry;
   } queue_rd_type;

   typedef struct packed {
      logic signed [COEF_W-1:0] coef;
      logic signed [CC_W-1:0]   cc2_re;
      logic signed [CC_W-1:0]   cc2_im;
      logic signed [CC_W-1:0]   cc_re;
      logic signed [CC_W-1:0]   cc_im;
   } cfg_type;

endpackage

/* sv/ggb_req_if.sv */
// sample channel interface
interface ggb_req_if import ggb_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink (input valid, input sample, output ready);
endinterface

/* sv/ggb_rsp_if.sv */
// bin result channel interface
interface ggb_rsp_if import ggb_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic signed [BIN_W-1:0] bin_re;
   logic signed [BIN_W-1:0] bin_im;

   modport source (output valid, output bin_re, output bin_im, input ready);
   modport sink (input valid, input bin_re, input bin_im, output ready);
endinterface

/* sv/ggb_front.sv */
// front end: takes samples, counts the frame and marks its last item
module ggb_front import ggb_pkg::*; #(
   parameter int MAX_FRAME = DEF_MAX_FRAME
) (
   input  logic                clock,
   input  logic                reset,
   ggb_req_if.sink             req,
   input  logic [FLEN_W-1:0]   frame_length,
   input  logic                q_full,
   output queue_wr_type        q_wr
);

   localparam int CNT_W = (MAX_FRAME > 2) ? $clog2(MAX_FRAME) : 1;
   localparam int LEN_W = $clog2(MAX_FRAME + 1);
   localparam int CMP_W = (LEN_W > FLEN_W) ? LEN_W : FLEN_W;

   logic [CNT_W-1:0] count_ff, count_in;
   logic [CMP_W-1:0] len_raw, len_eff, count_next;
   logic             accept, last;

   assign req.ready = ~q_full;
   assign accept    = req.valid & ~q_full;

   always_comb begin
      len_raw = CMP_W'(frame_length);
      if (len_raw < CMP_W'(2)) begin
         len_eff = CMP_W'(2);
      end else if (len_raw > CMP_W'(MAX_FRAME)) begin
         len_eff = CMP_W'(MAX_FRAME);
      end else begin
         len_eff = len_raw;
      end
      count_next = CMP_W'(count_ff) + CMP_W'(1);
      last       = count_next >= len_eff;
      count_in   = count_ff;
      if (accept) begin
         count_in = last ? '0 : count_next[CNT_W-1:0];
      end
   end

   assign q_wr.push         = accept;
   assign q_wr.entry.sample = req.sample;
   assign q_wr.entry.last   = last;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

/* sv/ggb_queue.sv */
// short item queue between front and back end
module ggb_queue import ggb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  queue_wr_type q_wr,
   input  logic         pop,
   output logic         full,
   output queue_rd_type q_rd
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

   qentry_type       entries_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [PTR_W:0]   fill_ff, fill_in;
   logic             do_push, do_pop;

   assign full    = fill_ff == (PTR_W + 1)'(QUEUE_DEPTH);
   assign do_push = q_wr.push & ~full;
   assign do_pop  = pop & (fill_ff != '0);

   assign q_rd.valid = fill_ff != '0;
   assign q_rd.entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= q_wr.entry;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

/* sv/ggb_back.sv */
// back end: recurrence and bin output on one shared half-width multiplier
module ggb_back import ggb_pkg::*; #(
   parameter int ACC_WIDTH = DEF_ACC_WIDTH
) (
   input  logic         clock,
   input  logic         reset,
   input  cfg_type      cfg,
   input  queue_rd_type q_rd,
   output logic         pop,
   ggb_rsp_if.source    rsp
);

   localparam int LO_W   = ACC_WIDTH / 2;
   localparam int HI_W   = ACC_WIDTH - LO_W;
   localparam int CH_W   = HI_W + 1;
   localparam int P_W    = CH_W + COEF_W;
   localparam int PROD_W = ACC_WIDTH + 18;

   localparam logic signed [PROD_W-1:0] RND_REC =
      {{(PROD_W-REC_SHIFT){1'b0}}, 1'b1, {(REC_SHIFT-1){1'b0}}};
   localparam logic signed [PROD_W-1:0] RND_BIN =
      {{(PROD_W-BIN_SHIFT){1'b0}}, 1'b1, {(BIN_SHIFT-1){1'b0}}};

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_REC  = 7'b0000010,
      ST_S0   = 7'b0000100,
      ST_RE   = 7'b0001000,
      ST_FRE  = 7'b0010000,
      ST_IM   = 7'b0100000,
      ST_FIM  = 7'b1000000
   } state_type;

   state_type                   state_ff, state_in;
   logic [1:0]                  phase_ff, phase_in;
   logic signed [PROD_W-1:0]    acc_ff, acc_in;
   logic signed [SAMPLE_W-1:0]  x_ff, x_in;
   logic                        last_ff, last_in;
   logic signed [ACC_WIDTH-1:0] s0_ff, s0_in, s1_ff, s1_in, s2_ff, s2_in;
   logic signed [BIN_W-1:0]     re_ff, re_in;
   logic                        out_valid_ff, out_valid_in;
   logic signed [BIN_W-1:0]     out_re_ff, out_re_in, out_im_ff, out_im_in;

   logic signed [ACC_WIDTH-1:0] op_val;
   logic signed [COEF_W-1:0]    op_b;
   logic                        neg, use_hi;
   logic signed [CH_W-1:0]      chunk;
   logic signed [P_W-1:0]       prod;
   logic signed [PROD_W-1:0]    prod_ext, term, acc_sum;
   logic signed [PROD_W-1:0]    rec_t, bin_t;
   logic [PROD_W-ACC_WIDTH:0]   rec_top;
   logic [PROD_W-BIN_W:0]       bin_top;
   logic signed [ACC_WIDTH-1:0] s0_sat;
   logic signed [BIN_W-1:0]     bin_sat;
   logic                        room;

   // operand select for the shared multiplier
   always_comb begin
      op_val = s1_ff;
      op_b   = cfg.coef;
      neg    = 1'b0;
      use_hi = phase_ff[0];
      unique case (state_ff)
         ST_RE: begin
            op_val = phase_ff[1] ? s1_ff : s0_ff;
            op_b   = phase_ff[1] ? COEF_W'(cfg.cc_re) : COEF_W'(cfg.cc2_re);
            neg    = phase_ff[1];
         end
         ST_IM: begin
            op_val = phase_ff[1] ? s1_ff : s0_ff;
            op_b   = phase_ff[1] ? COEF_W'(cfg.cc_im) : COEF_W'(cfg.cc2_im);
            neg    = phase_ff[1];
         end
         default: begin
            op_val = s1_ff;
            op_b   = cfg.coef;
         end
      endcase
   end

   // low half as unsigned, high half signed, recombined by shift
   assign chunk    = use_hi ? {op_val[ACC_WIDTH-1], op_val[ACC_WIDTH-1:LO_W]}
                            : {{(CH_W-LO_W){1'b0}}, op_val[LO_W-1:0]};
   assign prod     = chunk * op_b;
   assign prod_ext = PROD_W'(prod);
   assign term     = use_hi ? (prod_ext <<< LO_W) : prod_ext;
   assign acc_sum  = neg ? acc_ff - term : acc_ff + term;

   // rounding constant was preloaded into the accumulator
   always_comb begin
      rec_t   = (acc_ff >>> REC_SHIFT) + PROD_W'(x_ff) - PROD_W'(s2_ff);
      rec_top = rec_t[PROD_W-1:ACC_WIDTH-1];
      if ((&rec_top) || !(|rec_top)) begin
         s0_sat = rec_t[ACC_WIDTH-1:0];
      end else begin
         s0_sat = rec_t[PROD_W-1] ? {1'b1, {(ACC_WIDTH-1){1'b0}}}
                                  : {1'b0, {(ACC_WIDTH-1){1'b1}}};
      end
      bin_t   = acc_ff >>> BIN_SHIFT;
      bin_top = bin_t[PROD_W-1:BIN_W-1];
      if ((&bin_top) || !(|bin_top)) begin
         bin_sat = bin_t[BIN_W-1:0];
      end else begin
         bin_sat = bin_t[PROD_W-1] ? {1'b1, {(BIN_W-1){1'b0}}}
                                   : {1'b0, {(BIN_W-1){1'b1}}};
      end
   end

   assign room = ~out_valid_ff | rsp.ready;

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      acc_in       = acc_ff;
      x_in         = x_ff;
      last_in      = last_ff;
      s0_in        = s0_ff;
      s1_in        = s1_ff;
      s2_in        = s2_ff;
      re_in        = re_ff;
      out_valid_in = out_valid_ff & ~rsp.ready;
      out_re_in    = out_re_ff;
      out_im_in    = out_im_ff;
      pop          = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (q_rd.valid) begin
               pop      = 1'b1;
               x_in     = q_rd.entry.sample;
               last_in  = q_rd.entry.last;
               acc_in   = RND_REC;
               phase_in = 2'd0;
               state_in = ST_REC;
            end
         end
         ST_REC: begin
            acc_in   = acc_sum;
            phase_in = phase_ff + 2'd1;
            if (phase_ff[0]) begin
               state_in = ST_S0;
            end
         end
         ST_S0: begin
            if (last_ff) begin
               s0_in    = s0_sat;
               acc_in   = RND_BIN;
               phase_in = 2'd0;
               state_in = ST_RE;
            end else begin
               s2_in    = s1_ff;
               s1_in    = s0_sat;
               state_in = ST_IDLE;
            end
         end
         ST_RE: begin
            acc_in   = acc_sum;
            phase_in = phase_ff + 2'd1;
            if (phase_ff == 2'd3) begin
               state_in = ST_FRE;
            end
         end
         ST_FRE: begin
            re_in    = bin_sat;
            acc_in   = RND_BIN;
            phase_in = 2'd0;
            state_in = ST_IM;
         end
         ST_IM: begin
            acc_in   = acc_sum;
            phase_in = phase_ff + 2'd1;
            if (phase_ff == 2'd3) begin
               state_in = ST_FIM;
            end
         end
         ST_FIM: begin
            if (room) begin
               out_valid_in = 1'b1;
               out_re_in    = re_ff;
               out_im_in    = bin_sat;
               s1_in        = '0;
               s2_in        = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff    <= acc_in;
      x_ff      <= x_in;
      last_ff   <= last_in;
      s0_ff     <= s0_in;
      re_ff     <= re_in;
      out_re_ff <= out_re_in;
      out_im_ff <= out_im_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= 2'd0;
         s1_ff        <= '0;
         s2_ff        <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         s1_ff        <= s1_in;
         s2_ff        <= s2_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp.valid  = out_valid_ff;
   assign rsp.bin_re = out_re_ff;
   assign rsp.bin_im = out_im_ff;

   a_result_from_final: assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> $past(state_ff == ST_FIM))
      else $error("result raised outside the final step");

   a_mid_frame_returns: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_S0 && !last_ff) |=> state_ff == ST_IDLE)
      else $error("mid-frame item did not finish after the recurrence");

   a_re_four_terms: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FRE) |-> ($past(state_ff == ST_RE) && $past(phase_ff) == 2'd3))
      else $error("real part finished before all four partial products");

   a_frame_clears: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE && $past(state_ff == ST_FIM)) |-> (s1_ff == '0 && s2_ff == '0))
      else $error("recurrence state not cleared at end of frame");

endmodule

/* sv/generalized_goertzel_bin.sv */
// top level of the generalized goertzel bin with its control registers
//
//  channel   direction  handshake        payload
//  req_bus   in         valid/ready      sample (16b signed)
//  rsp_bus   out        valid/ready      bin_re, bin_im (48b signed)
//  apb       in         psel/penable     coef, cc2/cc terms, frame_length
//
// in the back end a sample that does not end a frame goes through queue
// pop, a low and a high half-width pass of the shared multiplier for coef*s1, one sum
// a frame-ending sample then needs eight more passes for the bin
// the front end takes one item per cycle while the two-entry queue has room
// reset clears the recurrence, frame count, queue and result valid flag
// a waiting result holds the back end in its final step; the queue fills behind it
module generalized_goertzel_bin import ggb_pkg::*; #(
   parameter int MAX_FRAME = DEF_MAX_FRAME,
   parameter int ACC_WIDTH = DEF_ACC_WIDTH
) (
   input  logic               clock,
   input  logic               reset,
   ggb_req_if.sink            req_bus,
   ggb_rsp_if.source          rsp_bus,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [PADDR_W-1:0] paddr,
   input  logic [PDATA_W-1:0] pwdata,
   output logic [PDATA_W-1:0] prdata,
   output logic               pready
);

   logic signed [COEF_W-1:0] coef_ff, coef_in;
   logic signed [CC_W-1:0]   cc2_re_ff, cc2_re_in, cc2_im_ff, cc2_im_in;
   logic signed [CC_W-1:0]   cc_re_ff, cc_re_in, cc_im_ff, cc_im_in;
   logic [FLEN_W-1:0]        flen_ff, flen_in;
   logic                     wr_en;
   logic [CSR_IDX_W-1:0]     idx;
   cfg_type                  cfg;
   queue_wr_type             q_wr;
   queue_rd_type             q_rd;
   logic                     q_full, q_pop;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign idx    = paddr[PADDR_W-1:2];

   always_comb begin
      coef_in   = coef_ff;
      cc2_re_in = cc2_re_ff;
      cc2_im_in = cc2_im_ff;
      cc_re_in  = cc_re_ff;
      cc_im_in  = cc_im_ff;
      flen_in   = flen_ff;
      if (wr_en) begin
         unique case (idx)
            REG_COEF:         coef_in   = pwdata[COEF_W-1:0];
            REG_CC2_RE:       cc2_re_in = pwdata[CC_W-1:0];
            REG_CC2_IM:       cc2_im_in = pwdata[CC_W-1:0];
            REG_CC_RE:        cc_re_in  = pwdata[CC_W-1:0];
            REG_CC_IM:        cc_im_in  = pwdata[CC_W-1:0];
            REG_FRAME_LENGTH: flen_in   = pwdata[FLEN_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_COEF:         prdata = PDATA_W'($unsigned(coef_ff));
         REG_CC2_RE:       prdata = PDATA_W'($unsigned(cc2_re_ff));
         REG_CC2_IM:       prdata = PDATA_W'($unsigned(cc2_im_ff));
         REG_CC_RE:        prdata = PDATA_W'($unsigned(cc_re_ff));
         REG_CC_IM:        prdata = PDATA_W'($unsigned(cc_im_ff));
         REG_FRAME_LENGTH: prdata = PDATA_W'(flen_ff);
         default:          prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff   <= '0;
         cc2_re_ff <= 16'sd16384;
         cc2_im_ff <= '0;
         cc_re_ff  <= 16'sd16384;
         cc_im_ff  <= '0;
         flen_ff   <= 13'd1024;
      end else begin
         coef_ff   <= coef_in;
         cc2_re_ff <= cc2_re_in;
         cc2_im_ff <= cc2_im_in;
         cc_re_ff  <= cc_re_in;
         cc_im_ff  <= cc_im_in;
         flen_ff   <= flen_in;
      end
   end

   assign cfg.coef   = coef_ff;
   assign cfg.cc2_re = cc2_re_ff;
   assign cfg.cc2_im = cc2_im_ff;
   assign cfg.cc_re  = cc_re_ff;
   assign cfg.cc_im  = cc_im_ff;

   ggb_front #(
      .MAX_FRAME (MAX_FRAME)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .req          (req_bus),
      .frame_length (flen_ff),
      .q_full       (q_full),
      .q_wr         (q_wr)
   );

   ggb_queue u_queue (
      .clock (clock),
      .reset (reset),
      .q_wr  (q_wr),
      .pop   (q_pop),
      .full  (q_full),
      .q_rd  (q_rd)
   );

   ggb_back #(
      .ACC_WIDTH (ACC_WIDTH)
   ) u_back (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .q_rd  (q_rd),
      .pop   (q_pop),
      .rsp   (rsp_bus)
   );

endmodule
